### hw/rtl/lskv_pkg.sv
// Package for the linear-scan key/value table: sizes, command, status and
// register codes, the slot record type and the key/value byte mask.
// Depends on nothing.
`default_nettype none

package lskv_pkg;

    localparam int CAPACITY    = 16;
    localparam int KEY_BYTES   = 8;
    localparam int VALUE_BYTES = 8;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_DELETE = 3'd1;
    localparam logic [2:0] CMD_GET    = 3'd2;
    localparam logic [2:0] CMD_UPDATE = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DUP  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_MISS = 2'd3;

    localparam logic [1:0] REG_ACTIVE_SLOTS = 2'd0;
    localparam logic [1:0] REG_MAX_KEY_LEN  = 2'd1;
    localparam logic [1:0] REG_MAX_VAL_LEN  = 2'd2;

    typedef struct packed {
        logic [63:0] key;
        logic [3:0]  klen;
        logic [63:0] val;
        logic [3:0]  vlen;
    } t_slot;

    function automatic logic [63:0] byte_mask(input logic [3:0] n);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            m[8*b +: 8] = (4'(b) < n) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/linear_scan_key_value_table_core.sv
// Linear-scan key/value table, top level: APB register bank, command
// sequencer and the slot memory it scans. Depends on lskv_pkg.
//
//  channel   dir  handshake                     beat contents
//  s_axis    in   s_axis_tvalid/s_axis_tready   command, key, value
//  m_axis    out  m_axis_tvalid/m_axis_tready   status, value, occupancy
//  apb       in   psel/penable/pready           register write/read
//
// A command scans the first scan slots between accept and result beat,
// scan = min(active_slots, CAPACITY): one slot memory read per cycle, then
// the registered read data, closing the scan and the write-back. The next beat
// is taken only once the sequencer is idle again, so commands do not overlap.
// Reset clears the slot valid flags at once; no clearing pass is needed.
// The result register frees the scan; write-back waits if it is still full.
`default_nettype none

module linear_scan_key_value_table_core (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [63:0] key_bytes, [67:64] key_length, [131:68] value_bytes, [135:132] value_length
    input  wire logic [135:0] s_axis_tdata,
    // [2:0] command
    input  wire logic [2:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [63:0] found_value, [67:64] found_value_length, [72:68] occupancy, rest zero
    output logic [79:0]       m_axis_tdata,
    // [1:0] status
    output logic [1:0]        m_axis_tuser,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int IDX_W = lskv_pkg::IDX_W;
    localparam int CNT_W = lskv_pkg::CNT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    // config
    logic [4:0] r_active;
    logic [3:0] r_max_klen;
    logic [3:0] r_max_vlen;

    // command
    t_state            r_state;
    logic [2:0]        r_cmd;
    logic [63:0]       r_key;
    logic [3:0]        r_klen;
    logic [63:0]       r_val;
    logic [3:0]        r_vlen;
    logic [CNT_W-1:0]  r_scan_len;
    logic [CNT_W-1:0]  r_rd_idx;
    logic              r_rd_pend;
    logic [IDX_W-1:0]  r_q_idx;
    logic              r_q_valid;
    lskv_pkg::t_slot   r_mem_q;
    logic              r_hit;
    logic [IDX_W-1:0]  r_hit_at;
    logic [63:0]       r_hit_val;
    logic [3:0]        r_hit_vlen;
    logic              r_have_free;
    logic [IDX_W-1:0]  r_free_at;
    logic [CNT_W-1:0]  r_count;
    logic [lskv_pkg::CAPACITY-1:0] r_valid;

    // result beat
    logic        r_out_valid;
    logic [1:0]  r_out_status;
    logic [63:0] r_out_fval;
    logic [3:0]  r_out_flen;
    logic [4:0]  r_out_occ;

    lskv_pkg::t_slot r_mem [lskv_pkg::CAPACITY];

    logic        cfg_we;
    logic        in_acc;
    logic [3:0]  in_klen;
    logic [3:0]  in_vlen;
    logic [3:0]  klen_c;
    logic [3:0]  vlen_c;
    logic [CNT_W+4:0] act_ext;
    logic [CNT_W-1:0] scan_len;
    logic        rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic        q_hit;

    logic             fin_go;
    logic [1:0]       f_status;
    logic [63:0]      f_fval;
    logic [3:0]       f_flen;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W+4:0] occ_ext;
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    lskv_pkg::t_slot  mem_wd;
    logic             set_valid;
    logic             clr_valid;
    logic             clr_all;

    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;

    always_comb begin
        unique case (paddr[3:2])
            lskv_pkg::REG_ACTIVE_SLOTS: prdata = {27'd0, r_active};
            lskv_pkg::REG_MAX_KEY_LEN:  prdata = {28'd0, r_max_klen};
            lskv_pkg::REG_MAX_VAL_LEN:  prdata = {28'd0, r_max_vlen};
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 5'd16;
            r_max_klen <= 4'd8;
            r_max_vlen <= 4'd8;
        end else if (cfg_we) begin
            unique case (paddr[3:2])
                lskv_pkg::REG_ACTIVE_SLOTS: r_active   <= pwdata[4:0];
                lskv_pkg::REG_MAX_KEY_LEN:  r_max_klen <= pwdata[3:0];
                lskv_pkg::REG_MAX_VAL_LEN:  r_max_vlen <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // effective key/value lengths and scan range
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc  = s_axis_tvalid & s_axis_tready;
    assign in_klen = s_axis_tdata[67:64];
    assign in_vlen = s_axis_tdata[135:132];

    always_comb begin
        klen_c = (in_klen > r_max_klen) ? r_max_klen : in_klen;
        if (klen_c > 4'(lskv_pkg::KEY_BYTES)) klen_c = 4'(lskv_pkg::KEY_BYTES);
        vlen_c = (in_vlen > r_max_vlen) ? r_max_vlen : in_vlen;
        if (vlen_c > 4'(lskv_pkg::VALUE_BYTES)) vlen_c = 4'(lskv_pkg::VALUE_BYTES);
        act_ext  = (CNT_W+5)'(r_active);
        scan_len = (act_ext > (CNT_W+5)'(lskv_pkg::CAPACITY)) ?
                   CNT_W'(lskv_pkg::CAPACITY) : act_ext[CNT_W-1:0];
    end

    assign rd_en   = (r_state == S_SCAN) && (r_rd_idx != r_scan_len);
    assign rd_addr = r_rd_idx[IDX_W-1:0];
    assign q_hit   = r_q_valid && (r_klen != 4'd0) && (r_mem_q.klen == r_klen)
                     && (r_mem_q.key == r_key);

    // write-back decision
    assign fin_go = (r_state == S_FINISH) && (!r_out_valid || m_axis_tready);

    always_comb begin
        f_status  = lskv_pkg::ST_OK;
        f_fval    = '0;
        f_flen    = '0;
        n_count   = r_count;
        mem_we    = 1'b0;
        mem_wa    = r_free_at;
        mem_wd    = '{key: r_key, klen: r_klen, val: r_val, vlen: r_vlen};
        set_valid = 1'b0;
        clr_valid = 1'b0;
        clr_all   = 1'b0;
        priority if (r_cmd == lskv_pkg::CMD_CLEAR) begin
            clr_all = 1'b1;
            n_count = '0;
        end else if (r_cmd <= lskv_pkg::CMD_UPDATE && r_klen == 4'd0) begin
            f_status = lskv_pkg::ST_MISS;
        end else if (r_cmd == lskv_pkg::CMD_INSERT) begin
            priority if (r_hit) begin
                f_status = lskv_pkg::ST_DUP;
            end else if (!r_have_free) begin
                f_status = lskv_pkg::ST_FULL;
            end else begin
                mem_we    = 1'b1;
                set_valid = 1'b1;
                n_count   = r_count + CNT_W'(1);
            end
        end else if (r_cmd <= lskv_pkg::CMD_UPDATE && !r_hit) begin
            f_status = lskv_pkg::ST_MISS;
        end else if (r_cmd == lskv_pkg::CMD_DELETE) begin
            mem_wa    = r_hit_at;
            clr_valid = 1'b1;
            if (r_count != '0) n_count = r_count - CNT_W'(1);
        end else if (r_cmd == lskv_pkg::CMD_GET) begin
            f_fval = r_hit_val;
            f_flen = r_hit_vlen;
        end else if (r_cmd == lskv_pkg::CMD_UPDATE) begin
            mem_wa = r_hit_at;
            mem_we = 1'b1;
        end else begin
            f_status = lskv_pkg::ST_OK;
        end
        occ_ext = (CNT_W+5)'(n_count);
    end

    // slot memory
    always_ff @(posedge i_clk) begin
        if (fin_go && mem_we) r_mem[mem_wa] <= mem_wd;
        if (rd_en) r_mem_q <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_pend   <= 1'b0;
            r_hit       <= 1'b0;
            r_have_free <= 1'b0;
            r_count     <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (m_axis_tready && !fin_go) r_out_valid <= 1'b0;
            r_rd_pend <= rd_en;
            if (rd_en) begin
                r_q_idx   <= rd_addr;
                r_q_valid <= r_valid[rd_addr];
                r_rd_idx  <= r_rd_idx + CNT_W'(1);
            end
            if (r_rd_pend) begin
                if (!r_q_valid) begin
                    if (!r_have_free) begin
                        r_have_free <= 1'b1;
                        r_free_at   <= r_q_idx;
                    end
                end else if (!r_hit && q_hit) begin
                    r_hit      <= 1'b1;
                    r_hit_at   <= r_q_idx;
                    r_hit_val  <= r_mem_q.val;
                    r_hit_vlen <= r_mem_q.vlen;
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_cmd       <= s_axis_tuser;
                        r_klen      <= klen_c;
                        r_key       <= s_axis_tdata[63:0] & lskv_pkg::byte_mask(klen_c);
                        r_vlen      <= vlen_c;
                        r_val       <= s_axis_tdata[131:68] & lskv_pkg::byte_mask(vlen_c);
                        r_scan_len  <= scan_len;
                        r_rd_idx    <= '0;
                        r_hit       <= 1'b0;
                        r_have_free <= 1'b0;
                        r_state     <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (!rd_en && !r_rd_pend) r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (fin_go) begin
                        r_count      <= n_count;
                        r_out_valid  <= 1'b1;
                        r_out_status <= f_status;
                        r_out_fval   <= f_fval;
                        r_out_flen   <= f_flen;
                        r_out_occ    <= occ_ext[4:0];
                        if (clr_all) begin
                            r_valid <= '0;
                        end else if (set_valid) begin
                            r_valid[mem_wa] <= 1'b1;
                        end else if (clr_valid) begin
                            r_valid[mem_wa] <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {7'd0, r_out_occ, r_out_flen, r_out_fval};

`ifndef SYNTHESIS
    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CNT_W'($countones(r_valid)))
        else $error("entry count differs from occupied slots");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_rd_idx <= r_scan_len)
        else $error("scan index past scan range");

    a_insert_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_go && set_valid |-> !r_valid[mem_wa])
        else $error("insert into an occupied slot");

    a_result_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == S_FINISH))
        else $error("result beat without write-back");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state == S_SCAN && r_rd_idx == '0)
        else $error("command accepted outside idle");
`endif

endmodule

`default_nettype wire
